// File: rtl/core/pid_pkg.sv
// shared types, constants and helper functions for the personal id validator
// depends on nothing; imported by every module under rtl/core
package pid_pkg;

    localparam int PID_DIGITS = 13;
    localparam int PID_VAL_W  = 44;
    localparam int PID_DIG_W  = PID_DIGITS * 4;

    // 10^12 is the weight of the leading digit, 10^13 the full id range
    localparam logic [PID_VAL_W-1:0] PID_TOP_POW = 44'd1_000_000_000_000;
    localparam logic [PID_VAL_W-1:0] PID_ID_MOD  = 44'd10_000_000_000_000;

    localparam logic [9:0]  PID_PIVOT_RESET = 10'd18;
    localparam logic [11:0] PID_BASE_HI     = 12'd2000;
    localparam logic [11:0] PID_BASE_LO     = 12'd1000;

    // result status codes
    localparam logic [1:0] PID_ST_VALID    = 2'd0;
    localparam logic [1:0] PID_ST_BAD_DATE = 2'd1;
    localparam logic [1:0] PID_ST_REM_TEN  = 2'd2;
    localparam logic [1:0] PID_ST_MISMATCH = 2'd3;

    // one slot of the digit chain
    typedef struct packed {
        logic                 valid;
        logic [PID_VAL_W-1:0] rem;
        logic [PID_DIG_W-1:0] digits;
    } pid_stage_t;

    // one finished result
    typedef struct packed {
        logic [1:0]  status;
        logic [6:0]  birth_day;
        logic [6:0]  birth_month;
        logic [11:0] birth_year;
        logic [6:0]  region_code;
        logic        is_female;
        logic [3:0]  expected_check;
    } pid_result_t;

    // multiples of the leading digit weight
    function automatic logic [PID_VAL_W-1:0] pid_top_mult(input logic [3:0] m);
        logic [PID_VAL_W-1:0] res;
        case (m)
            4'd1:    res = PID_TOP_POW;
            4'd2:    res = 44'd2_000_000_000_000;
            4'd3:    res = 44'd3_000_000_000_000;
            4'd4:    res = 44'd4_000_000_000_000;
            4'd5:    res = 44'd5_000_000_000_000;
            4'd6:    res = 44'd6_000_000_000_000;
            4'd7:    res = 44'd7_000_000_000_000;
            4'd8:    res = 44'd8_000_000_000_000;
            4'd9:    res = 44'd9_000_000_000_000;
            default: res = '0;
        endcase
        return res;
    endfunction

    // days in a month, months outside 1..12 are screened before this
    function automatic logic [4:0] pid_month_len(input logic [3:0] month, input logic leap);
        logic [4:0] res;
        case (month)
            4'd2:                      res = leap ? 5'd29 : 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   res = 5'd30;
            default:                   res = 5'd31;
        endcase
        return res;
    endfunction

endpackage

// File: rtl/core/pid_cell.sv
// one cell of the digit chain: peels the leading decimal digit off the remainder
// depends on pid_pkg
module pid_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  pid_pkg::pid_stage_t cell_in,
    output pid_pkg::pid_stage_t cell_out
);
    import pid_pkg::*;

    logic [3:0]           dig;
    logic [PID_VAL_W-1:0] low;
    logic [PID_VAL_W-1:0] low_x10;
    pid_stage_t           out_reg;

    // digit is the largest m with m * 10^12 <= rem
    always_comb begin
        dig = 4'd0;
        for (int m = 1; m <= 9; m++) begin
            if (cell_in.rem >= pid_top_mult(4'(m))) begin
                dig = 4'(m);
            end
        end
        low     = cell_in.rem - pid_top_mult(dig);
        low_x10 = (low << 3) + (low << 1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_reg.valid <= 1'b0;
        end else if (en) begin
            out_reg.valid <= cell_in.valid;
        end
        if (en) begin
            out_reg.rem    <= low_x10;
            out_reg.digits <= {cell_in.digits[PID_DIG_W-5:0], dig};
        end
    end

    assign cell_out = out_reg;

endmodule

// File: rtl/core/pid_eval.sv
// two-stage evaluation of the split digits: fields, date check, mod-11 check digit
// depends on pid_pkg
module pid_eval (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic [9:0]          pivot,
    input  pid_pkg::pid_stage_t eval_in,
    output logic                res_valid,
    output pid_pkg::pid_result_t res
);
    import pid_pkg::*;

    logic [3:0]  d [1:PID_DIGITS];
    logic [6:0]  day;
    logic [6:0]  month;
    logic [9:0]  y3;
    logic [6:0]  yy;
    logic        lo_century;
    logic [1:0]  cent_mod4;
    logic        leap;
    logic        month_ok;
    logic        date_ok;
    logic [8:0]  sum;

    logic        s1_valid_reg;
    logic [6:0]  s1_day_reg;
    logic [6:0]  s1_month_reg;
    logic [11:0] s1_year_reg;
    logic [6:0]  s1_region_reg;
    logic        s1_female_reg;
    logic        s1_date_ok_reg;
    logic [8:0]  s1_sum_reg;
    logic [3:0]  s1_last_reg;

    logic [15:0] q_prod;
    logic [5:0]  q_est;
    logic [8:0]  r_est;
    logic [3:0]  rem11;
    logic [3:0]  expected;
    logic [1:0]  status;

    logic        s2_valid_reg;
    pid_result_t s2_res_reg;

    always_comb begin
        for (int k = 1; k <= PID_DIGITS; k++) begin
            d[k] = eval_in.digits[(PID_DIGITS-k)*4 +: 4];
        end
        day   = 7'(d[1]) * 7'd10 + 7'(d[2]);
        month = 7'(d[3]) * 7'd10 + 7'(d[4]);
        y3    = 10'(d[5]) * 10'd100 + 10'(d[6]) * 10'd10 + 10'(d[7]);
        yy    = 7'(d[6]) * 7'd10 + 7'(d[7]);
        lo_century = (y3 < pivot);
        // century number is 20 + d5 or 10 + d5, so mod 4 is d5 or d5 + 2
        cent_mod4  = lo_century ? d[5][1:0] : (d[5][1:0] + 2'd2);
        leap = (yy == 7'd0) ? (cent_mod4 == 2'd0) : (yy[1:0] == 2'd0);
        month_ok = (month >= 7'd1) && (month <= 7'd12);
        date_ok  = month_ok && (day >= 7'd1)
                   && (day <= 7'(pid_month_len(month[3:0], leap)));
        sum = 9'd7 * (9'(d[1]) + 9'(d[7])) + 9'd6 * (9'(d[2]) + 9'(d[8]))
            + 9'd5 * (9'(d[3]) + 9'(d[9])) + 9'd4 * (9'(d[4]) + 9'(d[10]))
            + 9'd3 * (9'(d[5]) + 9'(d[11])) + 9'd2 * (9'(d[6]) + 9'(d[12]));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en) begin
            s1_valid_reg <= eval_in.valid;
        end
        if (en) begin
            s1_day_reg     <= day;
            s1_month_reg   <= month;
            s1_year_reg    <= 12'(y3) + (lo_century ? PID_BASE_HI : PID_BASE_LO);
            s1_region_reg  <= 7'(d[8]) * 7'd10 + 7'(d[9]);
            s1_female_reg  <= (d[10] >= 4'd5);
            s1_date_ok_reg <= date_ok;
            s1_sum_reg     <= sum;
            s1_last_reg    <= d[PID_DIGITS];
        end
    end

    // sum mod 11: quotient estimate 93/1024 is at most one low
    always_comb begin
        q_prod = 16'(s1_sum_reg) * 16'd93;
        q_est  = q_prod[15:10];
        r_est  = s1_sum_reg - 9'(q_est) * 9'd11;
        rem11  = (r_est >= 9'd11) ? 4'(r_est - 9'd11) : r_est[3:0];
        // check digit is 11 - rem, with 11 and 10 shown as 0
        expected = (rem11 <= 4'd1) ? 4'd0 : (4'd11 - rem11);
        if (!s1_date_ok_reg) begin
            status = PID_ST_BAD_DATE;
        end else if (rem11 == 4'd1) begin
            status = PID_ST_REM_TEN;
        end else if (expected != s1_last_reg) begin
            status = PID_ST_MISMATCH;
        end else begin
            status = PID_ST_VALID;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (en) begin
            s2_valid_reg <= s1_valid_reg;
        end
        if (en) begin
            s2_res_reg.status         <= status;
            s2_res_reg.birth_day      <= s1_day_reg;
            s2_res_reg.birth_month    <= s1_month_reg;
            s2_res_reg.birth_year     <= s1_year_reg;
            s2_res_reg.region_code    <= s1_region_reg;
            s2_res_reg.is_female      <= s1_female_reg;
            s2_res_reg.expected_check <= expected;
        end
    end

    assign res_valid = s2_valid_reg;
    assign res       = s2_res_reg;

endmodule

// File: rtl/core/personal_id_validator.sv
// top level of the personal id validator: input fold, digit chain, evaluation
// depends on pid_pkg, pid_cell and pid_eval
//
// takes one 13-digit id per item and returns one result item per id, one
// item per clock in steady state. the pipe is 16 register stages deep:
// one input register that holds the folded id, a chain of 13 cells that
// each peel one decimal digit per cycle, and two evaluation stages (fields
// and date check, then the mod-11 check digit and status). the whole pipe
// stalls as one when the result is held, so s_tready follows
// !m_tvalid || m_tready. century_pivot is written through cfg_* and should
// only change while no item is in flight.
module personal_id_validator (
    input  logic        aclk,
    input  logic        aresetn,
    // input items
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [43:0] id_number, [47:44] zero
    // result items
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [1:0] status, [8:2] birth_day, [15:9] birth_month,
                                   // [27:16] birth_year, [34:28] region_code,
                                   // [35] is_female, [39:36] expected_check
    // century pivot register write
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [9:0]  cfg_data
);
    import pid_pkg::*;

    logic                 en;
    logic [9:0]           pivot_reg;
    logic [PID_VAL_W-1:0] id_raw;
    logic [PID_VAL_W-1:0] id_fold;
    pid_stage_t           front_reg;
    pid_stage_t           chain [0:PID_DIGITS];
    logic                 res_valid;
    pid_result_t          res;

    // single pipeline enable: advance unless a finished item is held
    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pivot_reg <= PID_PIVOT_RESET;
        end else if (cfg_valid) begin
            pivot_reg <= cfg_data;
        end
    end

    // ids of 10^13 and up keep only their 13 low digits; one subtract is enough
    // since 2^44 < 2 * 10^13
    assign id_raw  = s_tdata[PID_VAL_W-1:0];
    assign id_fold = (id_raw >= PID_ID_MOD) ? (id_raw - PID_ID_MOD) : id_raw;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            front_reg.valid <= 1'b0;
        end else if (en) begin
            front_reg.valid <= s_tvalid;
        end
        if (en) begin
            front_reg.rem    <= id_fold;
            front_reg.digits <= '0;
        end
    end

    assign chain[0] = front_reg;

    // digit chain, most significant digit first
    for (genvar g = 0; g < PID_DIGITS; g++) begin : g_cell
        pid_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .cell_in  (chain[g]),
            .cell_out (chain[g+1])
        );
    end

    pid_eval u_eval (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .pivot     (pivot_reg),
        .eval_in   (chain[PID_DIGITS]),
        .res_valid (res_valid),
        .res       (res)
    );

    // the second evaluation stage is the output register
    assign m_tvalid = res_valid;
    assign m_tdata  = {res.expected_check, res.is_female, res.region_code,
                       res.birth_year, res.birth_month, res.birth_day, res.status};

`ifndef SYNTH
    // check digit stays a decimal digit
    a_check_digit: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[39:36] <= 4'd9))
        else $error("expected_check out of range");

    // remainder ten always reports a zero check digit
    a_rem_ten_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[1:0] == PID_ST_REM_TEN)) |-> (m_tdata[39:36] == 4'd0))
        else $error("remainder ten with nonzero check digit");

    // a valid id carries a real month and day
    a_valid_date: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tdata[1:0] == PID_ST_VALID)) |->
            ((m_tdata[15:9] >= 7'd1) && (m_tdata[15:9] <= 7'd12)
             && (m_tdata[8:2] >= 7'd1) && (m_tdata[8:2] <= 7'd31)))
        else $error("valid status with impossible date");

    // a held result stalls the input side
    a_stall_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |-> !s_tready)
        else $error("input accepted while result held");
`endif

endmodule
